/* sv/ame_pkg.sv */
package ame_pkg;

    localparam int ADDR_BITS       = 8;
    localparam int WORD_BITS       = 32;
    localparam int DEPTH           = 1 << ADDR_BITS;
    localparam int KIND_BITS       = 4;
    localparam int FIELD_ADDR_BITS = 8;
    localparam int IMM_BITS        = 32;
    localparam int SHOWN_BITS      = 32;

    typedef logic [WORD_BITS-1:0]       word_t;
    typedef logic [ADDR_BITS-1:0]       addr_t;
    typedef logic [KIND_BITS-1:0]       kind_t;
    typedef logic [FIELD_ADDR_BITS-1:0] field_addr_t;
    typedef logic [IMM_BITS-1:0]        imm_t;
    typedef logic [SHOWN_BITS-1:0]      shown_t;

    localparam kind_t OP_SET = 4'd0;
    localparam kind_t OP_SHW = 4'd1;
    localparam kind_t OP_ADD = 4'd2;
    localparam kind_t OP_LDR = 4'd3;
    localparam kind_t OP_MUL = 4'd4;
    localparam kind_t OP_SUB = 4'd5;
    localparam kind_t OP_DIV = 4'd6;
    localparam kind_t OP_INC = 4'd7;
    localparam kind_t OP_DEC = 4'd8;
    localparam kind_t OP_MOV = 4'd9;
    localparam kind_t OP_STR = 4'd10;

    // Address bits beyond the memory depth are dropped; missing ones are zero.
    function automatic addr_t to_addr(input field_addr_t a);
        addr_t r;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            r[i] = (i < FIELD_ADDR_BITS) ? a[i] : 1'b0;
        end
        return r;
    endfunction

    // Sign-extend or cut the immediate to the word width.
    function automatic word_t imm_to_word(input imm_t v);
        word_t r;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            r[i] = (i < IMM_BITS) ? v[i] : v[IMM_BITS-1];
        end
        return r;
    endfunction

    // Sign-extend or cut a memory word to the width of the shown value.
    function automatic shown_t word_to_shown(input word_t w);
        shown_t r;
        for (int i = 0; i < SHOWN_BITS; i++)
        begin
            r[i] = (i < WORD_BITS) ? w[i] : w[WORD_BITS-1];
        end
        return r;
    endfunction

endpackage

/* sv/ame_ram.sv */
module ame_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* sv/ame_div.sv */
module ame_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ame_pkg::word_t dividend,
    input  ame_pkg::word_t divisor,
    output logic          done,
    output ame_pkg::word_t quotient
);

    import ame_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                neg_reg;
    word_t               dvs_reg;
    word_t               quo_reg;
    word_t               rem_reg;

    logic [WORD_BITS:0]  shifted;
    logic [WORD_BITS:0]  diff;

    // One restoring step per cycle on the magnitudes.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[WORD_BITS-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(WORD_BITS);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            dvs_reg <= divisor[WORD_BITS-1] ? word_t'(-divisor) : divisor;
            quo_reg <= dividend[WORD_BITS-1] ? word_t'(-dividend) : dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!diff[WORD_BITS])
            begin
                rem_reg <= diff[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = neg_reg ? word_t'(-quo_reg) : quo_reg;

endmodule

/* sv/accumulator_machine_executor.sv */
// Channel   Direction  Handshake                Payload
// inst      in         inst_valid / inst_stall  kind, addr_a, addr_b, addr_c,
//                                               has_b, has_c, immediate
// res       out        res_valid / res_stall    shown_value, is_error
//
// Most instructions issue the memory reads on the accept edge and are
// modified and written back in the next cycle. MOV and MUL add one more state
// (a second write, or a registered product). A DIV with a nonzero divisor
// waits in S_DIV for the one-bit-per-cycle divider to finish.
// Reset clears the accumulator and the per-word valid bits, so every word
// reads as zero until written; no clearing pass is needed.
// A stalled result is held in the output register; SHW and a division by
// zero wait in the execute cycle until that register is free.
module accumulator_machine_executor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  inst_valid,
    output logic                  inst_stall,
    input  ame_pkg::kind_t        kind,
    input  ame_pkg::field_addr_t  addr_a,
    input  ame_pkg::field_addr_t  addr_b,
    input  ame_pkg::field_addr_t  addr_c,
    input  logic                  has_b,
    input  logic                  has_c,
    input  logic signed [31:0]    immediate,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic signed [31:0]    shown_value,
    output logic                  is_error
);

    import ame_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOV2 = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0]       state_reg, state_next;
    word_t            acc_reg, acc_next;
    logic [DEPTH-1:0] vld_reg;

    // Instruction captured at the accept edge.
    kind_t kind_reg;
    addr_t a_reg, b_reg, c_reg;
    logic  hb_reg, hc_reg;
    word_t imm_reg;
    logic  va_reg, vb_reg;

    word_t prod_reg, prod_next;

    logic   res_valid_reg;
    shown_t shown_reg;
    logic   err_reg;

    logic  accept;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    word_t rd_a, rd_b;
    word_t wa, wb, opx, opy;
    logic  noop, to_mem, out_free;
    logic  emit, emit_err;
    logic  res_commit;
    word_t res_word;
    logic  div_start, div_done;
    word_t div_q;

    assign accept     = inst_valid && !inst_stall;
    assign inst_stall = (state_reg != S_IDLE);

    // Word memory; both operand reads are launched on the accept edge and
    // hold their data for the rest of the instruction.
    ame_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (to_addr(addr_a)),
        .rd_addr_b (to_addr(addr_b)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    ame_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opx),
        .divisor  (opy),
        .done     (div_done),
        .quotient (div_q)
    );

    // A word that was never written reads as zero.
    assign wa = va_reg ? rd_a : '0;
    assign wb = vb_reg ? rd_b : '0;

    // Two-operand forms use the accumulator and word a; three-operand forms
    // use words a and b. A destination without a second operand is a no-op.
    assign opx      = hb_reg ? wa : acc_reg;
    assign opy      = hb_reg ? wb : wa;
    assign noop     = hc_reg && !hb_reg;
    assign to_mem   = hb_reg && hc_reg;
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        wr_en      = 1'b0;
        wr_addr    = a_reg;
        wr_data    = '0;
        emit       = 1'b0;
        emit_err   = 1'b0;
        res_commit = 1'b0;
        res_word   = '0;
        div_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (kind_reg)
                    OP_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_data = imm_reg;
                    end
                    OP_SHW:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EXEC;
                        end
                    end
                    OP_LDR:
                    begin
                        acc_next = wa;
                    end
                    OP_STR:
                    begin
                        wr_en    = 1'b1;
                        wr_data  = acc_reg;
                        acc_next = '0;
                    end
                    OP_INC:
                    begin
                        wr_en   = 1'b1;
                        wr_data = wa + 1'b1;
                    end
                    OP_DEC:
                    begin
                        wr_en   = 1'b1;
                        wr_data = wa - 1'b1;
                    end
                    OP_MOV:
                    begin
                        // Clear the source first so a move onto itself keeps
                        // the word.
                        wr_en      = 1'b1;
                        wr_data    = '0;
                        state_next = S_MOV2;
                    end
                    OP_ADD:
                    begin
                        res_commit = !noop;
                        res_word   = opx + opy;
                    end
                    OP_SUB:
                    begin
                        res_commit = !noop;
                        res_word   = opx - opy;
                    end
                    OP_MUL:
                    begin
                        if (!noop)
                        begin
                            prod_next  = word_t'(opx * opy);
                            state_next = S_MUL;
                        end
                    end
                    OP_DIV:
                    begin
                        if (!noop)
                        begin
                            if (opy == '0)
                            begin
                                if (out_free)
                                begin
                                    emit     = 1'b1;
                                    emit_err = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_EXEC;
                                end
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                    end
                    default:
                    begin
                        // Unused opcodes are ignored.
                    end
                endcase
            end
            S_MOV2:
            begin
                wr_en      = 1'b1;
                wr_addr    = b_reg;
                wr_data    = wa;
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                res_commit = 1'b1;
                res_word   = prod_reg;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_commit = 1'b1;
                    res_word   = div_q;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Arithmetic results go to word c or to the accumulator.
        if (res_commit)
        begin
            if (to_mem)
            begin
                wr_en   = 1'b1;
                wr_addr = c_reg;
                wr_data = res_word;
            end
            else
            begin
                acc_next = res_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            a_reg    <= to_addr(addr_a);
            b_reg    <= to_addr(addr_b);
            c_reg    <= to_addr(addr_c);
            hb_reg   <= has_b;
            hc_reg   <= has_c;
            imm_reg  <= imm_to_word(imm_t'(immediate));
            va_reg   <= vld_reg[to_addr(addr_a)];
            vb_reg   <= vld_reg[to_addr(addr_b)];
        end
        prod_reg <= prod_next;
        if (emit)
        begin
            shown_reg <= emit_err ? '0 : word_to_shown(wa);
            err_reg   <= emit_err;
        end
    end

    assign res_valid   = res_valid_reg;
    assign shown_value = $signed(shown_reg);
    assign is_error    = err_reg;

`ifndef NO_ASSERTIONS
    // Every accepted instruction enters the execute cycle next.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted instruction did not enter execute");

    // The memory is never written while no instruction is in flight.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != S_IDLE))
        else $error("memory write while idle");

    // A new result only comes out of the execute cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == S_EXEC))
        else $error("result raised outside execute");

    // The divider finishes only while the control waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide wait");
`endif

endmodule
